// ===== hw/rtl/v7e_pkg.sv =====
`timescale 1ns / 1ps

package v7e_pkg;

    // Input value port width and default encoded value width
    localparam int VALUE_PORT_W    = 64;
    localparam int VALUE_WIDTH_DEF = 64;

    // Encoding constants
    localparam int          GROUP_BITS = 7;
    localparam int          MAX_BYTES  = 9;
    localparam int          CNT_W      = 4;
    localparam logic [7:0]  CONT_FLAG  = 8'h80;

    // Depth of the descriptor queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Control part of one encode job
    typedef struct packed {
        logic [CNT_W-1:0] cnt;   // bytes to emit, 1..MAX_BYTES
        logic             full;  // final byte carries 8 bits
    } t_desc;

endpackage

// ===== hw/rtl/v7e_front.sv =====
`timescale 1ns / 1ps

module v7e_front #(
    parameter int VALUE_WIDTH = v7e_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_in_valid,
    input  logic [v7e_pkg::VALUE_PORT_W-1:0] i_value,
    input  logic [3:0]                      i_max_bytes,
    input  logic                            i_q_full,
    output logic                            o_in_stall,
    output logic                            o_push,
    output logic [VALUE_WIDTH-1:0]          o_push_value,
    output v7e_pkg::t_desc                  o_push_desc
);

    logic [VALUE_WIDTH-1:0]      v;
    logic [v7e_pkg::CNT_W-1:0]   budget;
    logic [v7e_pkg::CNT_W-1:0]   groups;
    logic                        full;

    // Saturate the budget and keep the low value bits
    assign v      = i_value[VALUE_WIDTH-1:0];
    assign budget = (i_max_bytes > 4'(v7e_pkg::MAX_BYTES)) ?
                    v7e_pkg::CNT_W'(v7e_pkg::MAX_BYTES) : i_max_bytes;

    // Count the 7-bit groups the value needs
    always_comb begin
        groups = v7e_pkg::CNT_W'(1);
        for (int k = 1; k < v7e_pkg::MAX_BYTES; k++) begin
            if ((v >> (v7e_pkg::GROUP_BITS * k)) != '0) begin
                groups = groups + v7e_pkg::CNT_W'(1);
            end
        end
    end

    // Full form once the value does not fit in budget-1 groups
    assign full = (groups >= budget);

    assign o_in_stall        = i_q_full;
    assign o_push            = i_in_valid && !i_q_full && (budget != '0);
    assign o_push_value      = v;
    assign o_push_desc.full  = full;
    assign o_push_desc.cnt   = full ? budget : groups;

endmodule

// ===== hw/rtl/v7e_queue.sv =====
`timescale 1ns / 1ps

module v7e_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = v7e_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers with wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!do_push && do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/v7e_back.sv =====
`timescale 1ns / 1ps

module v7e_back #(
    parameter int VALUE_WIDTH = v7e_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  logic [VALUE_WIDTH-1:0] i_q_value,
    input  v7e_pkg::t_desc         i_q_desc,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_out_byte,
    output logic                   o_last
);

    logic [VALUE_WIDTH-1:0]    r_val;
    logic [v7e_pkg::CNT_W-1:0] r_idx;
    logic                      r_full;
    logic                      r_busy;
    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_last;

    logic                      adv;
    logic                      done;
    logic [6:0]                sh;
    logic [VALUE_WIDTH-1:0]    shifted;
    logic [7:0]                n_byte;

    // Emit a byte when the output register is free or draining
    assign adv   = r_busy && (!r_out_valid || !i_out_stall);
    assign done  = adv && (r_idx == '0);
    assign o_pop = i_q_valid && (!r_busy || done);

    // Select the group: shift by 7*idx, plus one in the full form
    assign sh      = {r_idx, 3'b000} - 7'(r_idx) + 7'(r_full);
    assign shifted = r_val >> sh;

    always_comb begin
        if (r_idx == '0) begin
            n_byte = r_full ? r_val[7:0] : {1'b0, r_val[6:0]};
        end else begin
            n_byte = v7e_pkg::CONT_FLAG | {1'b0, shifted[6:0]};
        end
    end

    // Sequence the current job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_val  <= i_q_value;
            r_idx  <= i_q_desc.cnt - v7e_pkg::CNT_W'(1);
            r_full <= i_q_desc.full;
        end else if (adv) begin
            r_idx  <= r_idx - v7e_pkg::CNT_W'(1);
        end
    end

    // Hold the output item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= n_byte;
            r_out_last <= (r_idx == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

endmodule

// ===== hw/rtl/varint_7bit_encoder_top.sv =====
// Throughput: one byte per cycle from the serializer while i_out_stall is low; an item
// occupies it for its 1..9 bytes, and an item with a zero budget is taken from the input
// but never queued and emits nothing.
// A two-entry descriptor queue lets the input take items while the serializer works.
// Reset (synchronous, active low) empties the queue and the output register.
`timescale 1ns / 1ps

module varint_7bit_encoder_top #(
    parameter int VALUE_WIDTH = v7e_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [v7e_pkg::VALUE_PORT_W-1:0] i_value,
    input  logic [3:0]                       i_max_bytes,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [7:0]                       o_out_byte,
    output logic                             o_last
);

    localparam int Q_W = VALUE_WIDTH + $bits(v7e_pkg::t_desc);

    logic                   push, pop, q_full, q_valid;
    logic [VALUE_WIDTH-1:0] push_value;
    v7e_pkg::t_desc         push_desc;
    logic [Q_W-1:0]         q_data;
    v7e_pkg::t_desc         q_desc;
    logic [VALUE_WIDTH-1:0] q_value;

    // Classify incoming items
    v7e_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_in_valid   (i_in_valid),
        .i_value      (i_value),
        .i_max_bytes  (i_max_bytes),
        .i_q_full     (q_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_push_value (push_value),
        .o_push_desc  (push_desc)
    );

    // Buffer jobs between front and back
    v7e_queue #(.WIDTH(Q_W), .DEPTH(v7e_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_value, push_desc}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_value = q_data[Q_W-1 -: VALUE_WIDTH];
    assign q_desc  = q_data[$bits(v7e_pkg::t_desc)-1:0];

    // Serialize bytes
    v7e_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_value   (q_value),
        .i_q_desc    (q_desc),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

// ===== tb/tb_varint_7bit_encoder_top.sv =====
`timescale 1ns / 1ps

module tb_varint_7bit_encoder_top;

    // One encoded byte as it leaves the block
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } varint_byte_t;

    // One stimulus row: typed rows carry their bytes, first byte in the top lane
    typedef struct packed {
        logic [v7e_pkg::VALUE_PORT_W-1:0] value;
        logic [3:0]                       budget;
        logic                             typed;
        logic [3:0]                       n_bytes;
        logic [71:0]                      bytes;
    } stim_row_t;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 73;
    localparam int DRAIN_CYCLES = 24;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic [v7e_pkg::VALUE_PORT_W-1:0] i_value     = '0;
    logic [3:0]                       i_max_bytes = '0;
    logic                             i_out_stall = 1'b0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    logic [7:0]                       o_out_byte;
    logic                             o_last;

    varint_byte_t varint_bytes_due[$];
    varint_byte_t head_byte;
    stim_row_t    directed_rows [N_DIRECTED];
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    varint_7bit_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_max_bytes (i_max_bytes),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t: %s: want %h got %h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Queue the bytes that encoding one value under one budget must produce
    task automatic queue_varint_bytes(input logic [63:0] v, input logic [3:0] budget);
        int b;
        int n;
        int i;
        b = (budget > 4'd9) ? 9 : int'(budget);
        if (b == 0) begin
            return;
        end
        if (b == 1) begin
            varint_bytes_due.push_back('{v[7:0], 1'b1});
        end else if ((v >> (7 * (b - 1))) != 64'h0) begin
            // all B bytes used, final byte carries eight bits
            for (i = b - 1; i >= 1; i--) begin
                varint_bytes_due.push_back('{8'h80 | 8'((v >> (7 * i + 1)) & 64'h7F), 1'b0});
            end
            varint_bytes_due.push_back('{v[7:0], 1'b1});
        end else begin
            // fewest seven-bit groups
            n = 1;
            while (n < b - 1 && (v >> (7 * n)) != 64'h0) begin
                n++;
            end
            for (i = n - 1; i >= 1; i--) begin
                varint_bytes_due.push_back('{8'h80 | 8'((v >> (7 * i)) & 64'h7F), 1'b0});
            end
            varint_bytes_due.push_back('{{1'b0, v[6:0]}, 1'b1});
        end
    endtask

    // Offer one item, hold it through stalls, record its bytes once taken
    task automatic offer_item(input stim_row_t r);
        int j;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_value     <= r.value;
        i_max_bytes <= r.budget;
        do @(posedge i_clk); while (o_in_stall);
        if (r.typed) begin
            for (j = 0; j < int'(r.n_bytes); j++) begin
                varint_bytes_due.push_back('{r.bytes[71 - 8 * j -: 8], j == r.n_bytes - 1});
            end
        end else begin
            queue_varint_bytes(r.value, r.budget);
        end
    endtask

    // Build a random item: mostly values of random bit length, some on group edges
    function automatic stim_row_t random_row();
        stim_row_t   r;
        int          kind;
        int          len;
        int          k;
        logic [63:0] raw;
        raw  = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            len     = $urandom_range(0, 64);
            r.value = (len == 64) ? raw : raw & ((64'h1 << len) - 64'h1);
        end else if (kind <= 7) begin
            k       = $urandom_range(1, 9);
            r.value = (64'h1 << (7 * k)) - 64'($urandom_range(0, 1));
        end else begin
            r.value = raw;
        end
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            r.budget = 4'd0;
        end else if (kind == 1) begin
            r.budget = 4'd1;
        end else if (kind <= 3) begin
            r.budget = 4'($urandom_range(10, 15));
        end else begin
            r.budget = 4'($urandom_range(2, 9));
        end
        r.typed   = 1'b0;
        r.n_bytes = '0;
        r.bytes   = '0;
        return r;
    endfunction

    // Receiver: random stall, check every byte taken against the oldest one due
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (varint_bytes_due.size() == 0) begin
                    report_mismatch("unexpected byte", 8'h00, o_out_byte);
                end else begin
                    head_byte = varint_bytes_due.pop_front();
                    if (o_out_byte !== head_byte.data) begin
                        report_mismatch("out_byte", head_byte.data, o_out_byte);
                    end
                    if (o_last !== head_byte.last) begin
                        report_mismatch("last", {7'h0, head_byte.last}, {7'h0, o_last});
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial begin
        // zero budget, budget of one, zero value, saturated budgets, group edges, mixed patterns
        directed_rows[0]  = '{64'h0, 4'd0, 1'b1, 4'd0, 72'h0};
        directed_rows[1]  = '{64'h0, 4'd1, 1'b1, 4'd1, {8'h00, 64'h0}};
        directed_rows[2]  = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 4'd1, {8'hFF, 64'h0}};
        directed_rows[3]  = '{64'h1234_5678_9ABC_DEF0, 4'd1, 1'b1, 4'd1, {8'hF0, 64'h0}};
        directed_rows[4]  = '{64'h0, 4'd2, 1'b1, 4'd1, {8'h00, 64'h0}};
        directed_rows[5]  = '{64'h0, 4'd9, 1'b1, 4'd1, {8'h00, 64'h0}};
        directed_rows[6]  = '{64'h7F, 4'd2, 1'b1, 4'd1, {8'h7F, 64'h0}};
        directed_rows[7]  = '{64'h7F, 4'd9, 1'b1, 4'd1, {8'h7F, 64'h0}};
        directed_rows[8]  = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b1, 4'd9, {72{1'b1}}};
        directed_rows[9]  = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 4'd9, {72{1'b1}}};
        directed_rows[10] = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd10, 1'b1, 4'd9, {72{1'b1}}};
        directed_rows[11] = '{64'h80, 4'd2, 1'b0, 4'd0, 72'h0};
        directed_rows[12] = '{64'h80, 4'd9, 1'b0, 4'd0, 72'h0};
        directed_rows[13] = '{64'h3FFF, 4'd3, 1'b0, 4'd0, 72'h0};
        directed_rows[14] = '{64'h4000, 4'd3, 1'b0, 4'd0, 72'h0};
        directed_rows[15] = '{64'h8000_0000_0000_0000, 4'd9, 1'b0, 4'd0, 72'h0};
        directed_rows[16] = '{64'h0100_0000_0000_0000, 4'd9, 1'b0, 4'd0, 72'h0};
        directed_rows[17] = '{64'h00FF_FFFF_FFFF_FFFF, 4'd9, 1'b0, 4'd0, 72'h0};
        directed_rows[18] = '{64'h00FF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 4'd0, 72'h0};
        directed_rows[19] = '{64'hAAAA_AAAA_AAAA_AAAA, 4'd5, 1'b0, 4'd0, 72'h0};
        directed_rows[20] = '{64'h5555_5555_5555_5555, 4'd12, 1'b0, 4'd0, 72'h0};
        directed_rows[21] = '{64'h0123_4567_89AB_CDEF, 4'd11, 1'b0, 4'd0, 72'h0};
        directed_rows[22] = '{64'd300, 4'd13, 1'b0, 4'd0, 72'h0};
        directed_rows[23] = '{64'h1F_FFFF, 4'd4, 1'b0, 4'd0, 72'h0};
        directed_rows[24] = '{64'h3FFF_FFFF, 4'd14, 1'b0, 4'd0, 72'h0};

        // Hold reset, then release it
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sparse sender, heavy receiver stall
        send_idle_pct  = 6;
        recv_stall_pct = 82;
        for (int r = 0; r < N_DIRECTED; r++) begin
            offer_item(directed_rows[r]);
        end
        for (int r = 0; r < N_RANDOM; r++) begin
            offer_item(random_row());
        end

        // Heavy sender idle, light receiver stall
        send_idle_pct  = 82;
        recv_stall_pct = 6;
        for (int r = 0; r < N_RANDOM; r++) begin
            offer_item(random_row());
        end

        // Full rate on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int r = 0; r < N_RANDOM; r++) begin
            offer_item(random_row());
        end
        i_in_valid <= 1'b0;

        // Drain what is still due, then allow for stray bytes
        while (varint_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
